// ===== rtl/core/uhps_pkg.sv =====
package uhps_pkg;

    // Character codes that steer the parse.
    localparam logic [7:0] CHAR_COLON = 8'd58;
    localparam logic [7:0] CHAR_SLASH = 8'd47;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;

    // Result kinds.
    localparam logic [1:0] KIND_HOST    = 2'd0;
    localparam logic [1:0] KIND_PATH    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [15:0] DEFAULT_PORT_RESET = 16'd80;

    // Port characters kept after the colon.
    localparam int PORT_CHARS  = 5;
    localparam int PORT_CNT_W  = $clog2(PORT_CHARS + 1);
    localparam logic [PORT_CNT_W-1:0] PORT_CNT_MAX = PORT_CNT_W'(PORT_CHARS);

    // Port conversion widths and saturation.
    localparam int ACC_W   = 17;
    localparam int PORT_W  = 18;
    localparam int MUL_W   = ACC_W + 4;
    localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] ACC_LIMIT = ACC_W'((2 ** ACC_W - 1) / 10);

    // Result queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QUEUE_CW-1:0] QUEUE_ROOM_LIMIT = QUEUE_CW'(QUEUE_DEPTH - 2);

    typedef enum logic [3:0] {
        MODE_SEEK = 4'b0001,
        MODE_HOST = 4'b0010,
        MODE_PORT = 4'b0100,
        MODE_PATH = 4'b1000
    } t_mode;

    typedef enum logic [3:0] {
        CONV_BLANK = 4'b0001,
        CONV_SIGN  = 4'b0010,
        CONV_DIGIT = 4'b0100,
        CONV_DONE  = 4'b1000
    } t_conv;

    typedef enum logic [2:0] {
        SEP_NONE        = 3'b001,
        SEP_COLON       = 3'b010,
        SEP_COLON_SLASH = 3'b100
    } t_sep;

    typedef struct packed {
        logic [1:0]               kind;
        logic [7:0]               out_char;
        logic signed [PORT_W-1:0] port;
        logic                     valid_res;
        logic                     path_given;
        logic                     end_of_run;
    } t_result;

    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result res0;
        t_result res1;
    } t_push;

endpackage

// ===== rtl/core/uhps_ifs.sv =====
interface uhps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface uhps_out_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        kind;
    logic [7:0]                        out_char;
    logic signed [uhps_pkg::PORT_W-1:0] port;
    logic                              valid_res;
    logic                              path_given;
    logic                              end_of_run;

    modport source (output valid, output kind, output out_char, output port,
                    output valid_res, output path_given, output end_of_run,
                    input ready);
    modport sink   (input valid, input kind, input out_char, input port,
                    input valid_res, input path_given, input end_of_run,
                    output ready);
endinterface

interface uhps_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/url_host_port_path_splitter.sv =====
// URL host, port and path splitter.
// The i_in channel carries one URL byte per transfer (char_code) with last
// marking the final byte. The o_out channel carries results: a host byte, a
// path byte (the first path slash included), or, after the final byte, one
// summary transfer with the port, the separator flag and the path flag. The
// i_cfg channel writes the 16-bit default port; it is ready whenever reset is
// released, and a write is meant to happen only while no results are outstanding.
// A byte accepted into the input register is parsed there and written to the
// result queue, from which it leaves. Throughput is one byte per cycle while the
// queue has room; the final byte of a URL that also emits a byte produces two
// results, and the result queue absorbs the extra one.
// The rate is set by the single parse stage behind the input register and by
// the four-entry result queue that feeds the ready output one result per cycle.
// Reset empties the input register and the queue, returns the parser to
// seeking the double slash, and sets the default port to 80. While reset is
// applied, both input channels hold ready low. When the receiver stalls,
// results collect in the queue; once it cannot take two more, the parse stage
// holds its byte and i_in.ready falls.
module url_host_port_path_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    uhps_in_if.sink     i_in,
    uhps_cfg_if.sink    i_cfg,
    uhps_out_if.source  o_out
);

    uhps_pkg::t_push push;
    logic            room;

    // Parse stage: input register, run state and the config register.
    uhps_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_room  (room),
        .o_push  (push)
    );

    // Result queue: takes up to two results per cycle, sends one.
    uhps_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/core/uhps_parser.sv =====
module uhps_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    uhps_in_if.sink           i_in,
    uhps_cfg_if.sink          i_cfg,
    input  logic              i_room,
    output uhps_pkg::t_push   o_push
);

    // Input register.
    logic       r_stage_valid;
    logic [7:0] r_char;
    logic       r_last;

    // Parse state.
    uhps_pkg::t_mode                   r_mode, n_mode;
    logic                              r_slash_pend, n_slash_pend;
    uhps_pkg::t_sep                    r_sep, n_sep;
    logic                              r_sep_seen, n_sep_seen;
    logic [uhps_pkg::PORT_CNT_W-1:0]   r_port_cnt, n_port_cnt;
    uhps_pkg::t_conv                   r_conv, n_conv;
    logic                              r_neg, n_neg;
    logic [uhps_pkg::ACC_W-1:0]        r_accum, n_accum;
    logic [uhps_pkg::PORT_W-1:0]       r_port_val, n_port_val;
    logic                              r_port_closed, n_port_closed;
    logic [15:0]                       r_default_port;

    logic                              fire;
    logic                              is_colon, is_slash, is_blank, is_digit, is_sign;
    logic                              emit_byte;
    logic [1:0]                        emit_kind;
    logic [uhps_pkg::MUL_W-1:0]        acc_mul;
    uhps_pkg::t_result                 byte_res, sum_res;

    // Neither channel takes a transfer while reset is applied.
    assign fire        = r_stage_valid && i_room;
    assign i_in.ready  = i_rst_n && (!r_stage_valid || fire);
    assign i_cfg.ready = i_rst_n;

    assign is_colon = (r_char == uhps_pkg::CHAR_COLON);
    assign is_slash = (r_char == uhps_pkg::CHAR_SLASH);
    assign is_blank = (r_char == uhps_pkg::CHAR_SPACE) ||
                      ((r_char >= uhps_pkg::CHAR_TAB) && (r_char <= uhps_pkg::CHAR_CR));
    assign is_digit = (r_char >= uhps_pkg::CHAR_ZERO) && (r_char <= uhps_pkg::CHAR_NINE);
    assign is_sign  = (r_char == uhps_pkg::CHAR_PLUS) || (r_char == uhps_pkg::CHAR_MINUS);

    // accum * 10 + digit, the digit being the low nibble of an ASCII digit.
    assign acc_mul = ({{(uhps_pkg::MUL_W - uhps_pkg::ACC_W){1'b0}}, r_accum} << 3)
                   + ({{(uhps_pkg::MUL_W - uhps_pkg::ACC_W){1'b0}}, r_accum} << 1)
                   + {{(uhps_pkg::MUL_W - 4){1'b0}}, r_char[3:0]};

    always_comb begin
        n_mode        = r_mode;
        n_slash_pend  = r_slash_pend;
        n_sep_seen    = r_sep_seen;
        n_port_cnt    = r_port_cnt;
        n_conv        = r_conv;
        n_neg         = r_neg;
        n_accum       = r_accum;
        n_port_val    = r_port_val;
        n_port_closed = r_port_closed;
        emit_byte     = 1'b0;
        emit_kind     = uhps_pkg::KIND_HOST;

        // Track the ":" "/" "/" sequence anywhere in the text.
        if (is_colon) begin
            n_sep = uhps_pkg::SEP_COLON;
        end else if (is_slash && (r_sep == uhps_pkg::SEP_COLON)) begin
            n_sep = uhps_pkg::SEP_COLON_SLASH;
        end else if (is_slash && (r_sep == uhps_pkg::SEP_COLON_SLASH)) begin
            n_sep      = uhps_pkg::SEP_NONE;
            n_sep_seen = 1'b1;
        end else begin
            n_sep = uhps_pkg::SEP_NONE;
        end

        unique case (r_mode)
            uhps_pkg::MODE_SEEK: begin
                if (is_slash && r_slash_pend) begin
                    n_slash_pend = 1'b0;
                    n_mode       = uhps_pkg::MODE_HOST;
                end else begin
                    n_slash_pend = is_slash;
                end
            end
            uhps_pkg::MODE_HOST: begin
                if (is_colon) begin
                    n_mode = uhps_pkg::MODE_PORT;
                end else if (is_slash) begin
                    // No port given: the current default is latched.
                    n_port_val    = {{(uhps_pkg::PORT_W - 16){1'b0}}, r_default_port};
                    n_port_closed = 1'b1;
                    n_mode        = uhps_pkg::MODE_PATH;
                    emit_byte     = 1'b1;
                    emit_kind     = uhps_pkg::KIND_PATH;
                end else begin
                    emit_byte = 1'b1;
                    emit_kind = uhps_pkg::KIND_HOST;
                end
            end
            uhps_pkg::MODE_PORT: begin
                if (is_slash) begin
                    n_port_val = r_neg ?
                        (uhps_pkg::PORT_W'(0) - {1'b0, r_accum}) : {1'b0, r_accum};
                    n_port_closed = 1'b1;
                    n_mode        = uhps_pkg::MODE_PATH;
                    emit_byte     = 1'b1;
                    emit_kind     = uhps_pkg::KIND_PATH;
                end else if (r_port_cnt < uhps_pkg::PORT_CNT_MAX) begin
                    n_port_cnt = r_port_cnt + uhps_pkg::PORT_CNT_W'(1);
                    if (r_conv == uhps_pkg::CONV_DONE) begin
                        n_conv = r_conv;
                    end else if ((r_conv == uhps_pkg::CONV_BLANK) && is_blank) begin
                        n_conv = r_conv;
                    end else if ((r_conv == uhps_pkg::CONV_BLANK) && is_sign) begin
                        n_neg  = (r_char == uhps_pkg::CHAR_MINUS);
                        n_conv = uhps_pkg::CONV_SIGN;
                    end else if (is_digit) begin
                        if ((r_accum > uhps_pkg::ACC_LIMIT) ||
                            (acc_mul > {{(uhps_pkg::MUL_W - uhps_pkg::ACC_W){1'b0}},
                                        uhps_pkg::ACC_MAX})) begin
                            n_accum = uhps_pkg::ACC_MAX;
                        end else begin
                            n_accum = acc_mul[uhps_pkg::ACC_W-1:0];
                        end
                        n_conv = uhps_pkg::CONV_DIGIT;
                    end else begin
                        n_conv = uhps_pkg::CONV_DONE;
                    end
                end
            end
            uhps_pkg::MODE_PATH: begin
                emit_byte = 1'b1;
                emit_kind = uhps_pkg::KIND_PATH;
            end
            default: begin
                n_mode = uhps_pkg::MODE_SEEK;
            end
        endcase
    end

    always_comb begin
        byte_res            = '0;
        byte_res.kind       = emit_kind;
        byte_res.out_char   = r_char;

        sum_res             = '0;
        sum_res.kind        = uhps_pkg::KIND_SUMMARY;
        sum_res.port        = n_port_closed ? n_port_val :
                              {{(uhps_pkg::PORT_W - 16){1'b0}}, r_default_port};
        sum_res.valid_res   = n_sep_seen;
        sum_res.path_given  = (n_mode == uhps_pkg::MODE_PATH);
        sum_res.end_of_run  = 1'b1;

        o_push.push0 = fire && (emit_byte || r_last);
        o_push.push1 = fire && emit_byte && r_last;
        o_push.res0  = emit_byte ? byte_res : sum_res;
        o_push.res1  = sum_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_stage_valid <= 1'b1;
        end else if (fire) begin
            r_stage_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_char <= i_in.char_code;
            r_last <= i_in.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_port <= uhps_pkg::DEFAULT_PORT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_default_port <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_last)) begin
            r_mode        <= uhps_pkg::MODE_SEEK;
            r_slash_pend  <= 1'b0;
            r_sep         <= uhps_pkg::SEP_NONE;
            r_sep_seen    <= 1'b0;
            r_port_cnt    <= '0;
            r_conv        <= uhps_pkg::CONV_BLANK;
            r_neg         <= 1'b0;
            r_accum       <= '0;
            r_port_val    <= '0;
            r_port_closed <= 1'b0;
        end else if (fire) begin
            r_mode        <= n_mode;
            r_slash_pend  <= n_slash_pend;
            r_sep         <= n_sep;
            r_sep_seen    <= n_sep_seen;
            r_port_cnt    <= n_port_cnt;
            r_conv        <= n_conv;
            r_neg         <= n_neg;
            r_accum       <= n_accum;
            r_port_val    <= n_port_val;
            r_port_closed <= n_port_closed;
        end
    end

endmodule

// ===== rtl/core/uhps_result_queue.sv =====
module uhps_result_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  uhps_pkg::t_push i_push,
    output logic            o_room,
    uhps_out_if.source      o_out
);

    uhps_pkg::t_result               r_mem [uhps_pkg::QUEUE_DEPTH];
    logic [uhps_pkg::QUEUE_AW-1:0]   r_wr, n_wr;
    logic [uhps_pkg::QUEUE_AW-1:0]   r_rd;
    logic [uhps_pkg::QUEUE_CW-1:0]   r_count, n_count;
    logic [uhps_pkg::QUEUE_AW-1:0]   wr_next;
    logic                            pop;
    uhps_pkg::t_result               head;

    // Room for the two results that one item may bring.
    assign o_room  = (r_count <= uhps_pkg::QUEUE_ROOM_LIMIT);
    assign pop     = o_out.valid && o_out.ready;
    assign wr_next = r_wr + uhps_pkg::QUEUE_AW'(1);
    assign head    = r_mem[r_rd];

    assign o_out.valid      = (r_count != '0);
    assign o_out.kind       = head.kind;
    assign o_out.out_char   = head.out_char;
    assign o_out.port       = head.port;
    assign o_out.valid_res  = head.valid_res;
    assign o_out.path_given = head.path_given;
    assign o_out.end_of_run = head.end_of_run;

    always_comb begin
        n_wr    = r_wr;
        n_count = r_count;
        if (i_push.push0 && i_push.push1) begin
            n_wr    = r_wr + uhps_pkg::QUEUE_AW'(2);
            n_count = n_count + uhps_pkg::QUEUE_CW'(2);
        end else if (i_push.push0) begin
            n_wr    = wr_next;
            n_count = n_count + uhps_pkg::QUEUE_CW'(1);
        end
        if (pop) begin
            n_count = n_count - uhps_pkg::QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_count <= n_count;
            if (pop) begin
                r_rd <= r_rd + uhps_pkg::QUEUE_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.push1) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

endmodule
